/* rtl/mrs_pkg.sv */
// ----------------------------------------------------------------------------
// mrs_pkg
// Shared types, codes and the CRC-16 byte step for the Modbus RTU register
// slave.
// ----------------------------------------------------------------------------
package mrs_pkg;

    localparam logic [7:0]  FN_READ_HOLDING = 8'h03;
    localparam logic [7:0]  FN_READ_INPUT   = 8'h04;
    localparam logic [7:0]  FN_WRITE_SINGLE = 8'h06;
    localparam logic [7:0]  FN_WRITE_EXC    = 8'h86;
    localparam logic [7:0]  EXC_ILLEGAL_VAL = 8'h03;
    localparam logic [7:0]  ID_INVALID      = 8'hFF;

    localparam logic        CFG_SLAVE_ID    = 1'b0;
    localparam logic        CFG_VERSION     = 1'b1;

    localparam logic [7:0]  SLAVE_ID_RESET  = 8'h01;
    localparam logic [31:0] VERSION_RESET   = 32'h302E3036;

    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;

    typedef struct packed {
        logic init;
        logic step;
    } t_crc_ctl;

    // one byte of CRC-16/MODBUS, lsb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* rtl/mrs_crc16.sv */
// ----------------------------------------------------------------------------
// mrs_crc16
// Shared CRC-16/MODBUS accumulator, advanced by one byte per step.
// ----------------------------------------------------------------------------
module mrs_crc16
    import mrs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_crc_ctl    i_ctl,
    input  logic [7:0]  i_data,
    output logic [15:0] o_crc
);

    logic [15:0] r_crc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else if (i_ctl.init) begin
            r_crc <= CRC_INIT;
        end else if (i_ctl.step) begin
            r_crc <= crc16_byte(r_crc, i_data);
        end
    end

    assign o_crc = r_crc;

endmodule

/* rtl/modbus_rtu_register_slave.sv */
// ----------------------------------------------------------------------------
// modbus_rtu_register_slave
// Sliding 8-byte request window, frame check and reply sequencer of a
// reduced Modbus RTU slave.
// ----------------------------------------------------------------------------
// channel   direction  tdata          tuser           tlast
// s         in         rx_byte [7:0]  -               -
// m         out        tx_byte [7:0]  loader_request  last_byte
// cfg       in         write enable, index (0 slave id, 1 version), data
//
// a byte that does not match address and function is checked and dropped;
// for a matching byte the shared CRC unit takes six window bytes for the
// frame CRC, then, but for an echo, 3, 5 or 7 reply bytes before the append
// the reply then leaves one byte per cycle, 5 to 9 bytes, slowed by
// m_tready; s_tready stays low until the last reply byte is taken
// synchronous reset clears the window, id override and sequencer
// ----------------------------------------------------------------------------
module modbus_rtu_register_slave
    import mrs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] tx_byte
    output logic        o_m_tlast,
    output logic        o_m_tuser,   // [0] loader_request
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_wdata
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CHECK   = 3'd1;
    localparam logic [2:0] ST_CRC_IN  = 3'd2;
    localparam logic [2:0] ST_DECIDE  = 3'd3;
    localparam logic [2:0] ST_CRC_OUT = 3'd4;
    localparam logic [2:0] ST_APPEND  = 3'd5;
    localparam logic [2:0] ST_SEND    = 3'd6;

    localparam logic [3:0] CRC_IN_LAST = 4'd5;
    localparam logic [3:0] LEN_EXC     = 4'd5;
    localparam logic [3:0] LEN_SHORT   = 4'd7;
    localparam logic [3:0] LEN_ECHO    = 4'd8;
    localparam logic [3:0] LEN_LONG    = 4'd9;

    logic [2:0]  r_state, n_state;
    logic [7:0]  r_win [8];
    logic [7:0]  r_reply [9];
    logic [3:0]  r_idx;
    logic [3:0]  r_len;
    logic        r_loader;
    logic        r_exc_mode;
    logic        r_id_over;
    logic [7:0]  r_written_id;
    logic [7:0]  r_init_id;
    logic [31:0] r_version;

    logic [7:0]  id;
    logic [7:0]  fn;
    logic [15:0] daddr;
    logic        hdr_ok;
    logic        crc_ok;
    logic        s_acc;
    logic        m_acc;
    logic        m_last;
    logic [3:0]  crc_out_last;
    logic [3:0]  idx_crc_lo;
    logic [3:0]  idx_crc_hi;
    logic [7:0]  crc_byte;
    logic [15:0] crc;
    t_crc_ctl    crc_ctl;

    assign id       = r_id_over ? r_written_id : r_init_id;
    assign fn       = r_win[1];
    assign daddr    = {r_win[2], r_win[3]};
    assign hdr_ok   = (r_win[0] == id) && ((fn == FN_READ_HOLDING) ||
                      (fn == FN_READ_INPUT) || (fn == FN_WRITE_SINGLE));
    assign crc_ok   = (crc == {r_win[7], r_win[6]});
    assign s_acc    = i_s_tvalid && o_s_tready;
    assign m_acc    = o_m_tvalid && i_m_tready;
    assign m_last   = (r_idx == r_len - 4'd1);
    assign crc_out_last = r_len - 4'd3;
    assign idx_crc_lo   = r_len - 4'd2;
    assign idx_crc_hi   = r_len - 4'd1;

    // one index walks the window for the frame CRC, the reply otherwise
    assign crc_byte     = (r_state == ST_CRC_IN) ? r_win[r_idx[2:0]] : r_reply[r_idx];
    assign crc_ctl.init = (r_state == ST_CHECK) || (r_state == ST_DECIDE);
    assign crc_ctl.step = (r_state == ST_CRC_IN) || (r_state == ST_CRC_OUT);

    mrs_crc16 u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (crc_ctl),
        .i_data  (crc_byte),
        .o_crc   (crc)
    );

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = (r_state == ST_SEND);
    assign o_m_tdata  = r_reply[r_idx];
    assign o_m_tlast  = m_last;
    assign o_m_tuser  = m_last && r_loader;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (s_acc) n_state = ST_CHECK;
            ST_CHECK:   n_state = hdr_ok ? ST_CRC_IN : ST_IDLE;
            ST_CRC_IN:  if (r_idx == CRC_IN_LAST) n_state = ST_DECIDE;
            ST_DECIDE: begin
                n_state = ST_IDLE;
                if (crc_ok) begin
                    case (fn)
                        FN_READ_HOLDING: begin
                            if ((daddr == 16'd0 && r_win[5] == 8'd1) ||
                                (daddr == 16'd1 && r_win[5] == 8'd2) ||
                                (daddr == 16'd2 && r_win[5] == 8'd1)) begin
                                n_state = ST_CRC_OUT;
                            end
                        end
                        FN_WRITE_SINGLE: begin
                            if (daddr == 16'd0) begin
                                n_state = (r_win[4] == 8'd0 && r_win[5] == 8'd1) ?
                                          ST_SEND : ST_CRC_OUT;
                            end else if (daddr == 16'd1) begin
                                n_state = (r_win[4] == 8'd0 && r_win[5] != 8'd0 &&
                                           r_win[5] != ID_INVALID) ? ST_SEND : ST_CRC_OUT;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CRC_OUT: if (r_idx == crc_out_last) n_state = ST_APPEND;
            ST_APPEND:  n_state = ST_SEND;
            ST_SEND:    if (m_acc && m_last) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= 4'd0;
            r_len        <= LEN_EXC;
            r_loader     <= 1'b0;
            r_exc_mode   <= 1'b0;
            r_id_over    <= 1'b0;
            r_written_id <= 8'h00;
            for (int k = 0; k < 8; k++) begin
                r_win[k] <= 8'h00;
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    if (s_acc) begin
                        for (int k = 0; k < 7; k++) begin
                            r_win[k] <= r_win[k+1];
                        end
                        r_win[7] <= i_s_tdata;
                    end
                    r_idx <= 4'd0;
                end
                ST_CRC_IN: r_idx <= r_idx + 4'd1;
                ST_DECIDE: begin
                    r_idx      <= 4'd0;
                    r_loader   <= 1'b0;
                    r_exc_mode <= 1'b0;
                    if (n_state == ST_SEND) begin
                        // echo of the request frame
                        r_len <= LEN_ECHO;
                        for (int k = 0; k < 8; k++) begin
                            r_reply[k] <= r_win[k];
                        end
                        if (daddr == 16'd0) begin
                            r_loader <= 1'b1;
                        end else begin
                            r_id_over    <= 1'b1;
                            r_written_id <= r_win[5];
                        end
                    end else if (n_state == ST_CRC_OUT) begin
                        if (fn == FN_WRITE_SINGLE) begin
                            r_len      <= LEN_EXC;
                            r_reply[0] <= id;
                            r_reply[1] <= FN_WRITE_EXC;
                            r_reply[2] <= EXC_ILLEGAL_VAL;
                            r_exc_mode <= (daddr == 16'd0);
                        end else begin
                            r_reply[0] <= id;
                            r_reply[1] <= FN_READ_HOLDING;
                            if (daddr == 16'd1) begin
                                r_len      <= LEN_LONG;
                                r_reply[2] <= 8'h04;
                                r_reply[3] <= r_version[31:24];
                                r_reply[4] <= r_version[23:16];
                                r_reply[5] <= r_version[15:8];
                                r_reply[6] <= r_version[7:0];
                            end else begin
                                r_len      <= LEN_SHORT;
                                r_reply[2] <= 8'h02;
                                r_reply[3] <= 8'h00;
                                r_reply[4] <= (daddr == 16'd2) ? id : 8'h00;
                            end
                        end
                    end
                end
                ST_CRC_OUT: r_idx <= r_idx + 4'd1;
                ST_APPEND: begin
                    r_idx               <= 4'd0;
                    r_reply[idx_crc_lo] <= crc[7:0];
                    r_reply[idx_crc_hi] <= crc[15:8];
                    // bad mode value leaves the exception in the window
                    if (r_exc_mode) begin
                        r_win[1] <= FN_WRITE_EXC;
                        r_win[2] <= EXC_ILLEGAL_VAL;
                        r_win[3] <= crc[7:0];
                        r_win[4] <= crc[15:8];
                    end
                    r_exc_mode <= 1'b0;
                end
                ST_SEND: if (m_acc && !m_last) r_idx <= r_idx + 4'd1;
                default: r_idx <= 4'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_id <= SLAVE_ID_RESET;
            r_version <= VERSION_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SLAVE_ID: r_init_id <= i_cfg_wdata[7:0];
                CFG_VERSION:  r_version <= i_cfg_wdata;
                default:      r_version <= r_version;
            endcase
        end
    end

endmodule

/* rtl/mrs_checker.sv */
// ----------------------------------------------------------------------------
// mrs_checker
// Port-level checks on the register slave's stream channels.
// ----------------------------------------------------------------------------
module mrs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast,
    input logic       o_m_tuser
);

    // a stalled reply byte holds
    a_m_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
        (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser)))
        else $error("reply byte changed while stalled");

    // no new byte is taken while a reply is going out
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready during reply");

    // loader request only on the final byte
    a_loader: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> o_m_tlast)
        else $error("loader request off the last byte");

    // an accepted byte is checked before the next one
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("ready straight after a transaction");

    // reply ends after its last transaction
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> (!o_m_tvalid && o_s_tready))
        else $error("reply continued past last byte");

endmodule

bind modbus_rtu_register_slave mrs_checker u_mrs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);

/* bench/modbus_rtu_register_slave_test.sv */
// ----------------------------------------------------------------------------
// modbus_rtu_register_slave_test
// Self-checking bench for the reduced Modbus RTU slave: request frames and
// noise go in on the byte stream, every reply byte is checked against an
// in-bench model of the window, id override and reply framing, under
// several register settings and with random stalls on both streams.
// ----------------------------------------------------------------------------
module modbus_rtu_register_slave_test;
    import mrs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 32;
    localparam int MAX_PRINTED   = 50;

    typedef logic [7:0] t_byte_buf [0:8];

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       loader;
    } t_tx_beat;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata   = 8'h00;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [7:0]  o_m_tdata;
    logic        o_m_tlast;
    logic        o_m_tuser;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_index = CFG_SLAVE_ID;
    logic [31:0] i_cfg_wdata = 32'h0;

    modbus_rtu_register_slave u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),   // [7:0] rx_byte
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),   // [7:0] tx_byte
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),   // [0] loader_request
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // model state
    logic [7:0]  rx_window [0:7];
    logic        id_overridden = 1'b0;
    logic [7:0]  written_id    = 8'h00;
    logic [7:0]  cfg_slave_id  = SLAVE_ID_RESET;
    logic [31:0] cfg_version   = VERSION_RESET;

    t_tx_beat    expected_reply_q [$];

    int          cycle_count    = 0;
    int          hold_until     = 0;
    int          tx_idle_pct    = 0;
    int          rx_idle_pct    = 0;
    int          error_count    = 0;
    int          bytes_sent     = 0;
    int          frames_sent    = 0;
    int          beats_checked  = 0;
    int          settings_used  = 1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reply bytes outstanding",
                     cycle_count, expected_reply_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver stalls: forced hold-off window, otherwise random idling
    always @(negedge i_clk) begin
        if (cycle_count < hold_until)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] exp);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("mismatch at cycle %0d: %s got %02h expected %02h",
                     cycle_count, what, got, exp);
    endtask

    always @(posedge i_clk) begin : reply_checker
        t_tx_beat exp_beat;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_reply_q.size() == 0) begin
                report_mismatch("unexpected reply byte", o_m_tdata, 8'h00);
            end else begin
                exp_beat = expected_reply_q.pop_front();
                beats_checked++;
                if (o_m_tdata !== exp_beat.data)
                    report_mismatch("tx_byte", o_m_tdata, exp_beat.data);
                if (o_m_tlast !== exp_beat.last)
                    report_mismatch("last_byte", {7'd0, o_m_tlast}, {7'd0, exp_beat.last});
                if (o_m_tuser !== exp_beat.loader)
                    report_mismatch("loader_request", {7'd0, o_m_tuser},
                                    {7'd0, exp_beat.loader});
            end
        end
    end

    function automatic logic [15:0] modbus_crc(input t_byte_buf bytes, input int count);
        logic [15:0] acc;
        acc = CRC_INIT;
        for (int i = 0; i < count; i++) begin
            acc = acc ^ {8'h00, bytes[i]};
            for (int b = 0; b < 8; b++)
                acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
        end
        return acc;
    endfunction

    function automatic logic [7:0] slave_in_force();
        return id_overridden ? written_id : cfg_slave_id;
    endfunction

    // shift one received byte into the window and queue the reply it causes
    task automatic predict_rx_byte(input logic [7:0] rx);
        t_byte_buf   reply;
        t_byte_buf   head;
        logic [7:0]  id;
        logic [7:0]  fn;
        logic [15:0] daddr;
        logic [15:0] crc;
        int          n;
        logic        framed;
        logic        loader;
        logic        rewrite;
        t_tx_beat    beat;

        id = slave_in_force();
        for (int k = 1; k < 8; k++)
            rx_window[k-1] = rx_window[k];
        rx_window[7] = rx;

        fn = rx_window[1];
        if (rx_window[0] != id)
            return;
        if (fn != FN_READ_HOLDING && fn != FN_READ_INPUT && fn != FN_WRITE_SINGLE)
            return;
        for (int k = 0; k < 9; k++)
            head[k] = (k < 8) ? rx_window[k] : 8'h00;
        if ({rx_window[7], rx_window[6]} != modbus_crc(head, 6))
            return;

        daddr   = {rx_window[2], rx_window[3]};
        n       = 0;
        framed  = 1'b0;
        loader  = 1'b0;
        rewrite = 1'b0;
        for (int k = 0; k < 9; k++)
            reply[k] = 8'h00;

        if (fn == FN_READ_HOLDING) begin
            reply[0] = id;
            reply[1] = FN_READ_HOLDING;
            framed   = 1'b1;
            if (daddr == 16'd0 && rx_window[5] == 8'h01) begin
                reply[2] = 8'h02;
                n = 7;
            end else if (daddr == 16'd1 && rx_window[5] == 8'h02) begin
                reply[2] = 8'h04;
                {reply[3], reply[4], reply[5], reply[6]} = cfg_version;
                n = 9;
            end else if (daddr == 16'd2 && rx_window[5] == 8'h01) begin
                reply[2] = 8'h02;
                reply[4] = id;
                n = 7;
            end
        end else if (fn == FN_WRITE_SINGLE) begin
            if (daddr == 16'd0) begin
                if (rx_window[4] == 8'h00 && rx_window[5] == 8'h01) begin
                    n = 8;
                    loader = 1'b1;
                end else begin
                    n = 5;
                    framed  = 1'b1;
                    rewrite = 1'b1;
                end
            end else if (daddr == 16'd1) begin
                if (rx_window[4] == 8'h00 && rx_window[5] != 8'h00 &&
                    rx_window[5] != 8'hFF) begin
                    written_id    = rx_window[5];
                    id_overridden = 1'b1;
                    n = 8;
                end else begin
                    n = 5;
                    framed = 1'b1;
                end
            end
            if (n == 8) begin
                for (int k = 0; k < 8; k++)
                    reply[k] = rx_window[k];
            end else if (n == 5) begin
                reply[0] = id;
                reply[1] = FN_WRITE_EXC;
                reply[2] = EXC_ILLEGAL_VAL;
            end
        end

        if (framed && n > 0) begin
            crc = modbus_crc(reply, n - 2);
            reply[n-2] = crc[7:0];
            reply[n-1] = crc[15:8];
        end
        // a rejected mode value leaves the exception header in the window
        if (rewrite) begin
            rx_window[1] = FN_WRITE_EXC;
            rx_window[2] = EXC_ILLEGAL_VAL;
            rx_window[3] = reply[3];
            rx_window[4] = reply[4];
        end
        for (int k = 0; k < n; k++) begin
            beat.data   = reply[k];
            beat.last   = (k == n - 1);
            beat.loader = (k == n - 1) && loader;
            expected_reply_q.push_back(beat);
        end
    endtask

    // called right after an accept edge or an idle pause, drives at the falling edge
    task automatic send_byte(input logic [7:0] value);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        predict_rx_byte(value);
        bytes_sent++;
    endtask

    task automatic send_request(input logic [7:0] slave, input logic [7:0] fn,
                                input logic [15:0] addr, input logic [15:0] value,
                                input logic corrupt_crc);
        t_byte_buf   req;
        logic [15:0] crc;
        req[0] = slave;
        req[1] = fn;
        {req[2], req[3]} = addr;
        {req[4], req[5]} = value;
        for (int k = 6; k < 9; k++)
            req[k] = 8'h00;
        crc = modbus_crc(req, 6);
        if (corrupt_crc)
            crc = crc ^ 16'($urandom_range(1, 65535));
        req[6] = crc[7:0];
        req[7] = crc[15:8];
        for (int k = 0; k < 8; k++)
            send_byte(req[k]);
        frames_sent++;
    endtask

    // sender goes quiet until every reply byte has come and the block settles
    task automatic wait_for_drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (expected_reply_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic index, input logic [31:0] value);
        wait_for_drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (index == CFG_SLAVE_ID)
            cfg_slave_id = value[7:0];
        else
            cfg_version = value;
    endtask

    task automatic apply_settings(input logic [7:0] slave_id, input logic [31:0] version);
        write_register(CFG_SLAVE_ID, {24'h0, slave_id});
        write_register(CFG_VERSION, version);
        settings_used++;
    endtask

    // mostly well-formed requests of random kind, some line noise in between
    task automatic run_random_traffic(input int byte_target, input bit allow_id_write);
        int          start_bytes;
        int          kind;
        logic [7:0]  id;
        logic [7:0]  lo;
        logic [15:0] word;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < byte_target) begin
            id = slave_in_force();
            if ($urandom_range(0, 99) < 20) begin
                repeat ($urandom_range(1, 5))
                    send_byte(8'($urandom_range(0, 255)));
            end else begin
                kind = $urandom_range(0, 11);
                if (kind == 5 && !allow_id_write)
                    kind = 6;
                case (kind)
                    0: send_request(id, FN_READ_HOLDING, 16'd0,
                                    {8'($urandom), 8'h01}, 1'b0);
                    1: send_request(id, FN_READ_HOLDING, 16'd1,
                                    {8'($urandom), 8'h02}, 1'b0);
                    2: send_request(id, FN_READ_HOLDING, 16'd2,
                                    {8'($urandom), 8'h01}, 1'b0);
                    3: send_request(id, FN_WRITE_SINGLE, 16'd0, 16'h0001, 1'b0);
                    4: begin
                        word = 16'($urandom_range(2, 65536)) - 16'd1;
                        if (word == 16'h0001)
                            word = 16'h0000;
                        send_request(id, FN_WRITE_SINGLE, 16'd0, word, 1'b0);
                    end
                    5: begin
                        case ($urandom_range(0, 3))
                            0:       lo = 8'h01;
                            1:       lo = 8'hFE;
                            default: lo = 8'($urandom_range(1, 254));
                        endcase
                        send_request(id, FN_WRITE_SINGLE, 16'd1, {8'h00, lo}, 1'b0);
                    end
                    6: begin
                        case ($urandom_range(0, 2))
                            0:       word = 16'h0000;
                            1:       word = 16'h00FF;
                            default: word = {8'($urandom_range(1, 255)), 8'($urandom)};
                        endcase
                        send_request(id, FN_WRITE_SINGLE, 16'd1, word, 1'b0);
                    end
                    7: send_request(id, FN_READ_INPUT, 16'($urandom_range(0, 3)),
                                    16'($urandom), 1'b0);
                    8: begin
                        if ($urandom_range(0, 1)) begin
                            send_request(id, FN_READ_HOLDING,
                                         16'($urandom_range(3, 65535)),
                                         16'($urandom), 1'b0);
                        end else begin
                            word = 16'($urandom_range(0, 2));
                            lo   = ((word == 16'd1) ? 8'h02 : 8'h01)
                                   + 8'($urandom_range(1, 254));
                            send_request(id, FN_READ_HOLDING, word,
                                         {8'($urandom), lo}, 1'b0);
                        end
                    end
                    9: send_request(id, FN_WRITE_SINGLE, 16'($urandom_range(2, 65535)),
                                    16'($urandom), 1'b0);
                    10: send_request(id ^ 8'($urandom_range(1, 255)), FN_READ_HOLDING,
                                     16'd1, 16'h0002, 1'b0);
                    default: send_request(id, FN_READ_HOLDING, 16'd1, 16'h0002, 1'b1);
                endcase
            end
        end
    endtask

    task automatic test_directed_requests();
        // reset settings: version read, mode read with a junk amount high byte,
        // loader request, then a rejected mode value that rewrites the window
        send_request(SLAVE_ID_RESET, FN_READ_HOLDING, 16'd1, 16'h0002, 1'b0);
        send_request(SLAVE_ID_RESET, FN_READ_HOLDING, 16'd0, 16'hFF01, 1'b0);
        send_request(SLAVE_ID_RESET, FN_WRITE_SINGLE, 16'd0, 16'h0001, 1'b0);
        send_request(SLAVE_ID_RESET, FN_WRITE_SINGLE, 16'd0, 16'h1234, 1'b0);
    endtask

    task automatic test_low_extremes();
        apply_settings(8'h00, 32'h0000_0000);
        run_random_traffic(65, 1'b0);
    endtask

    task automatic test_high_extremes();
        apply_settings(8'hFF, 32'hFFFF_FFFF);
        run_random_traffic(65, 1'b0);
    endtask

    task automatic test_receiver_hold_off();
        // a reply waits behind a long receiver stall while the next request is held off by s_tready
        @(posedge i_clk);
        hold_until = cycle_count + 600;
        send_request(slave_in_force(), FN_READ_HOLDING, 16'd1, 16'h0002, 1'b0);
        send_request(slave_in_force(), FN_READ_HOLDING, 16'd2, 16'h0001, 1'b0);
        repeat (3) send_byte(8'($urandom_range(0, 255)));
        wait_for_drain();
        send_request(slave_in_force(), FN_READ_HOLDING, 16'd0, 16'h0001, 1'b0);
    endtask

    task automatic test_id_override_traffic();
        apply_settings(8'($urandom_range(1, 254)), $urandom);
        run_random_traffic(75, 1'b1);
        send_request(slave_in_force(), FN_READ_HOLDING, 16'd2, 16'h0001, 1'b0);
    endtask

    initial begin
        for (int k = 0; k < 8; k++)
            rx_window[k] = 8'h00;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 35;
        rx_idle_pct = 81;
        test_directed_requests();
        test_low_extremes();

        tx_idle_pct = 81;
        rx_idle_pct = 35;
        test_high_extremes();
        test_receiver_hold_off();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_id_override_traffic();

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_reply_q.size() != 0)
            report_mismatch("reply bytes never sent", 8'(expected_reply_q.size()), 8'h00);

        $display("sent %0d request bytes in %0d frames plus noise, under %0d settings",
                 bytes_sent, frames_sent, settings_used);
        $display("checked %0d reply bytes, %0d mismatches", beats_checked, error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
